// ===== rtl/jsu_pkg.sv =====
// Package with the types, character codes and helper functions of the JSON string unescaper.
package jsu_pkg;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_BYTE      = 3'd0,
        ST_DONE      = 3'd1,
        ST_NOQUOTE   = 3'd2,
        ST_TRUNC_ESC = 3'd3,
        ST_TRUNC_UNI = 3'd4,
        ST_BAD_HEX   = 3'd5,
        ST_UNK_ESC   = 3'd6,
        ST_UNTERM    = 3'd7
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        t_status    status;
        logic       last;
    } t_result;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0]                   count;
        t_result [MAX_RESULTS-1:0]    item;
    } t_burst;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;

    localparam logic [7:0] UTF8_CONT = 8'h80;
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;

    // Returns the digit value in the low four bits and a valid flag on top.
    function automatic logic [4:0] hex_value(input logic [7:0] h);
        logic [4:0] v;
        v = 5'd0;
        if (h inside {[8'h30:8'h39]}) begin
            v = {1'b1, 4'(h - 8'h30)};
        end else if (h inside {[8'h61:8'h66]}) begin
            v = {1'b1, 4'(h - 8'h57)};
        end else if (h inside {[8'h41:8'h46]}) begin
            v = {1'b1, 4'(h - 8'h37)};
        end
        return v;
    endfunction

    // Maps a simple escape letter to its byte, with a valid flag on top.
    function automatic logic [8:0] escape_map(input logic [7:0] c);
        logic [8:0] v;
        case (c)
            CH_QUOTE:  v = {1'b1, CH_QUOTE};
            CH_BSLASH: v = {1'b1, CH_BSLASH};
            CH_SLASH:  v = {1'b1, CH_SLASH};
            CH_B:      v = {1'b1, 8'h08};
            CH_F:      v = {1'b1, 8'h0C};
            CH_N:      v = {1'b1, 8'h0A};
            CH_R:      v = {1'b1, 8'h0D};
            CH_T:      v = {1'b1, 8'h09};
            default:   v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/jsu_decode.sv =====
// Parser state machine that turns one accepted text word into up to three result words.
module jsu_decode (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_text_end,
    output jsu_pkg::t_burst o_burst
);

    jsu_pkg::t_phase r_phase, n_phase;
    logic [1:0]      r_hex_count, n_hex_count;
    logic [11:0]     r_code_point, n_code_point;

    logic [4:0]  hex_dig;
    logic [8:0]  esc_val;
    logic [15:0] cp_full;

    assign hex_dig = jsu_pkg::hex_value(i_data_byte);
    assign esc_val = jsu_pkg::escape_map(i_data_byte);
    assign cp_full = {r_code_point, hex_dig[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= jsu_pkg::PH_WAIT;
            r_hex_count  <= 2'd0;
            r_code_point <= 12'd0;
        end else begin
            r_phase      <= n_phase;
            r_hex_count  <= n_hex_count;
            r_code_point <= n_code_point;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_hex_count  = r_hex_count;
        n_code_point = r_code_point;
        if (i_accept) begin
            case (r_phase)
                jsu_pkg::PH_WAIT: begin
                    if (!i_text_end && i_data_byte == jsu_pkg::CH_QUOTE) begin
                        n_phase      = jsu_pkg::PH_STR;
                        n_hex_count  = 2'd0;
                        n_code_point = 12'd0;
                    end
                end
                jsu_pkg::PH_STR: begin
                    if (i_text_end || i_data_byte == jsu_pkg::CH_QUOTE) begin
                        n_phase = jsu_pkg::PH_WAIT;
                    end else if (i_data_byte == jsu_pkg::CH_BSLASH) begin
                        n_phase = jsu_pkg::PH_ESC;
                    end
                end
                jsu_pkg::PH_ESC: begin
                    if (i_text_end) begin
                        n_phase = jsu_pkg::PH_WAIT;
                    end else if (i_data_byte == jsu_pkg::CH_U) begin
                        n_phase      = jsu_pkg::PH_HEX;
                        n_hex_count  = 2'd0;
                        n_code_point = 12'd0;
                    end else if (esc_val[8]) begin
                        n_phase = jsu_pkg::PH_STR;
                    end else begin
                        n_phase = jsu_pkg::PH_WAIT;
                    end
                end
                jsu_pkg::PH_HEX: begin
                    if (i_text_end || !hex_dig[4]) begin
                        n_phase      = jsu_pkg::PH_WAIT;
                        n_hex_count  = 2'd0;
                        n_code_point = 12'd0;
                    end else if (r_hex_count == 2'd3) begin
                        n_phase      = jsu_pkg::PH_STR;
                        n_hex_count  = 2'd0;
                        n_code_point = 12'd0;
                    end else begin
                        n_hex_count  = r_hex_count + 2'd1;
                        n_code_point = {r_code_point[7:0], hex_dig[3:0]};
                    end
                end
                default: begin
                    n_phase = jsu_pkg::PH_WAIT;
                end
            endcase
        end
    end

    always_comb begin
        o_burst = '0;
        case (r_phase)
            jsu_pkg::PH_WAIT: begin
                if (!i_text_end && i_data_byte != jsu_pkg::CH_QUOTE) begin
                    o_burst.count          = 2'd1;
                    o_burst.item[0].status = jsu_pkg::ST_NOQUOTE;
                end
            end
            jsu_pkg::PH_STR: begin
                if (i_text_end) begin
                    o_burst.count          = 2'd1;
                    o_burst.item[0].status = jsu_pkg::ST_UNTERM;
                end else if (i_data_byte == jsu_pkg::CH_QUOTE) begin
                    o_burst.count          = 2'd1;
                    o_burst.item[0].status = jsu_pkg::ST_DONE;
                end else if (i_data_byte != jsu_pkg::CH_BSLASH) begin
                    o_burst.count            = 2'd1;
                    o_burst.item[0].out_byte = i_data_byte;
                end
            end
            jsu_pkg::PH_ESC: begin
                if (i_text_end) begin
                    o_burst.count          = 2'd1;
                    o_burst.item[0].status = jsu_pkg::ST_TRUNC_ESC;
                end else if (esc_val[8]) begin
                    o_burst.count            = 2'd1;
                    o_burst.item[0].out_byte = esc_val[7:0];
                end else if (i_data_byte != jsu_pkg::CH_U) begin
                    o_burst.count          = 2'd1;
                    o_burst.item[0].status = jsu_pkg::ST_UNK_ESC;
                end
            end
            jsu_pkg::PH_HEX: begin
                if (i_text_end) begin
                    o_burst.count          = 2'd1;
                    o_burst.item[0].status = jsu_pkg::ST_TRUNC_UNI;
                end else if (!hex_dig[4]) begin
                    o_burst.count          = 2'd1;
                    o_burst.item[0].status = jsu_pkg::ST_BAD_HEX;
                end else if (r_hex_count == 2'd3) begin
                    if (cp_full[15:7] == 9'd0) begin
                        o_burst.count            = 2'd1;
                        o_burst.item[0].out_byte = {1'b0, cp_full[6:0]};
                    end else if (cp_full[15:11] == 5'd0) begin
                        o_burst.count            = 2'd2;
                        o_burst.item[0].out_byte = jsu_pkg::UTF8_LEAD2 | {3'd0, cp_full[10:6]};
                        o_burst.item[1].out_byte = jsu_pkg::UTF8_CONT | {2'd0, cp_full[5:0]};
                    end else begin
                        o_burst.count            = 2'd3;
                        o_burst.item[0].out_byte = jsu_pkg::UTF8_LEAD3 | {4'd0, cp_full[15:12]};
                        o_burst.item[1].out_byte = jsu_pkg::UTF8_CONT | {2'd0, cp_full[11:6]};
                        o_burst.item[2].out_byte = jsu_pkg::UTF8_CONT | {2'd0, cp_full[5:0]};
                    end
                end
            end
            default: begin
                o_burst.count = 2'd0;
            end
        endcase
        if (o_burst.count != 2'd0) begin
            o_burst.item[o_burst.count - 2'd1].last = 1'b1;
        end
    end

endmodule

// ===== rtl/jsu_outq.sv =====
// Result register for a burst of up to three words, drained one per cycle while i_ready is high.
module jsu_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jsu_pkg::t_burst  i_burst,
    input  logic             i_ready,
    output logic             o_valid,
    output jsu_pkg::t_result o_item,
    output logic             o_can_load
);

    logic [1:0]       r_cnt, n_cnt;
    jsu_pkg::t_result r_slot [jsu_pkg::MAX_RESULTS];
    logic             pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_item     = r_slot[0];
    assign pop        = o_valid && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_burst.count;
        end else if (pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot[0] <= i_burst.item[0];
            r_slot[1] <= i_burst.item[1];
            r_slot[2] <= i_burst.item[2];
        end else if (pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

endmodule

// ===== rtl/json_string_unescape.sv =====
// Top level of the streaming JSON string unescaper.
//
// The slave channel takes raw text, one byte per word; tlast marks the end of
// the text and such a word carries no byte. The master channel gives decoded
// words: the byte in tdata and a status code in tuser (byte, done, or one of
// six error kinds), with tlast on the final word caused by one input word.
// An escape of the form backslash-u with four hex digits yields one to three
// UTF-8 bytes; surrogate halves are encoded as they stand.
// A result appears on the master side in the cycle after its input word is
// accepted. The block takes one input word per cycle while each word gives at
// most one result and m_axis_tready is high; a unicode escape that yields two
// or three bytes holds the slave side while the result register drains.
// When the receiver stalls, results wait in the result register and the slave
// side takes a new word only once the last pending result is being taken.
// Synchronous reset clears the result register and returns the parser to
// waiting for an opening quote.
module json_string_unescape (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // data_byte
    input  logic       s_axis_tlast,   // text_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte
    output logic [2:0] m_axis_tuser,   // status
    output logic       m_axis_tlast    // last_of_run
);

    logic             accept;
    jsu_pkg::t_burst  burst;
    jsu_pkg::t_result head;

    assign accept = s_axis_tvalid && s_axis_tready;

    jsu_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (s_axis_tdata),
        .i_text_end  (s_axis_tlast),
        .o_burst     (burst)
    );

    jsu_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_burst    (burst),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_item     (head),
        .o_can_load (s_axis_tready)
    );

    assign m_axis_tdata = head.out_byte;
    assign m_axis_tuser = head.status;
    assign m_axis_tlast = head.last;

endmodule

// ===== rtl/jsu_checker.sv =====
// Port-level checker for the JSON string unescaper and its bind to the top level.
module jsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // A stalled result word holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // Done and error words stand alone and carry a zero byte.
    a_status_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != jsu_pkg::ST_BYTE |->
            m_axis_tlast && m_axis_tdata == 8'd0)
        else $error("status word is not a lone zero word");

    // The input side only stalls while results are pending.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    // A multi-byte run continues without a gap.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("run of result words broken");

    // Nothing new is taken in while a run is still being delivered.
    a_no_take_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted in the middle of a run");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (.*);

// ===== test/json_string_unescape_tb.sv =====
// Self-checking testbench for the streaming JSON string unescaper.
module json_string_unescape_tb;

    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_WORDS = 310;
    localparam logic [7:0] ESC_LETTERS [8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH,
                                                jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
                                                jsu_pkg::CH_F, jsu_pkg::CH_N,
                                                jsu_pkg::CH_R, jsu_pkg::CH_T};

    class unescape_scoreboard;
        jsu_pkg::t_phase phase;
        logic [1:0] hex_cnt;
        logic [15:0] code_acc;
        jsu_pkg::t_result expected_words[$];
        int errors;
        int words_used;

        function new();
            phase = jsu_pkg::PH_WAIT;
            hex_cnt = 2'd0;
            code_acc = 16'd0;
            errors = 0;
            words_used = 0;
        endfunction

        function logic [4:0] digit_of(logic [7:0] c);
            if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
            if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
                return {1'b1, c[3:0] + 4'd9};
            return 5'd0;
        endfunction

        function void take_text_word(logic [7:0] b, logic e);
            logic [7:0] bytes_out[3];
            jsu_pkg::t_status fault;
            logic faulted;
            logic [4:0] d;
            logic [15:0] v;
            jsu_pkg::t_result r;
            int n;
            n = 0;
            faulted = 1'b0;
            fault = jsu_pkg::ST_BYTE;
            if (!(phase == jsu_pkg::PH_WAIT && e)) words_used++;
            case (phase)
                jsu_pkg::PH_WAIT: begin
                    if (!e && b == jsu_pkg::CH_QUOTE) begin
                        phase = jsu_pkg::PH_STR;
                        hex_cnt = 2'd0;
                        code_acc = 16'd0;
                    end else if (!e) begin
                        faulted = 1'b1;
                        fault = jsu_pkg::ST_NOQUOTE;
                    end
                end
                jsu_pkg::PH_STR: begin
                    if (e) begin
                        faulted = 1'b1;
                        fault = jsu_pkg::ST_UNTERM;
                    end else if (b == jsu_pkg::CH_QUOTE) begin
                        faulted = 1'b1;
                        fault = jsu_pkg::ST_DONE;
                    end else if (b == jsu_pkg::CH_BSLASH) begin
                        phase = jsu_pkg::PH_ESC;
                    end else begin
                        bytes_out[0] = b;
                        n = 1;
                    end
                end
                jsu_pkg::PH_ESC: begin
                    if (e) begin
                        faulted = 1'b1;
                        fault = jsu_pkg::ST_TRUNC_ESC;
                    end else begin
                        phase = jsu_pkg::PH_STR;
                        n = 1;
                        case (b)
                            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                                bytes_out[0] = b;
                            jsu_pkg::CH_B: bytes_out[0] = 8'h08;
                            jsu_pkg::CH_F: bytes_out[0] = 8'h0C;
                            jsu_pkg::CH_N: bytes_out[0] = 8'h0A;
                            jsu_pkg::CH_R: bytes_out[0] = 8'h0D;
                            jsu_pkg::CH_T: bytes_out[0] = 8'h09;
                            jsu_pkg::CH_U: begin
                                phase = jsu_pkg::PH_HEX;
                                hex_cnt = 2'd0;
                                code_acc = 16'd0;
                                n = 0;
                            end
                            default: begin
                                faulted = 1'b1;
                                fault = jsu_pkg::ST_UNK_ESC;
                                n = 0;
                            end
                        endcase
                    end
                end
                default: begin
                    d = digit_of(b);
                    if (e) begin
                        faulted = 1'b1;
                        fault = jsu_pkg::ST_TRUNC_UNI;
                    end else if (!d[4]) begin
                        faulted = 1'b1;
                        fault = jsu_pkg::ST_BAD_HEX;
                    end else begin
                        v = {code_acc[11:0], d[3:0]};
                        if (hex_cnt != 2'd3) begin
                            code_acc = v;
                            hex_cnt = hex_cnt + 2'd1;
                        end else begin
                            phase = jsu_pkg::PH_STR;
                            hex_cnt = 2'd0;
                            code_acc = 16'd0;
                            if (v < 16'h0080) begin
                                bytes_out[0] = v[7:0];
                                n = 1;
                            end else if (v < 16'h0800) begin
                                bytes_out[0] = {3'b110, v[10:6]};
                                bytes_out[1] = {2'b10, v[5:0]};
                                n = 2;
                            end else begin
                                bytes_out[0] = {4'b1110, v[15:12]};
                                bytes_out[1] = {2'b10, v[11:6]};
                                bytes_out[2] = {2'b10, v[5:0]};
                                n = 3;
                            end
                        end
                    end
                end
            endcase
            if (faulted) begin
                phase = jsu_pkg::PH_WAIT;
                hex_cnt = 2'd0;
                code_acc = 16'd0;
                bytes_out[0] = 8'd0;
                n = 1;
            end
            for (int i = 0; i < n; i++) begin
                r.out_byte = bytes_out[i];
                r.status = faulted ? fault : jsu_pkg::ST_BYTE;
                r.last = (i == n - 1);
                expected_words = {expected_words, r};
            end
        endfunction

        function void check_decoded_word(logic [7:0] b, logic [2:0] s, logic l);
            jsu_pkg::t_result want;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, data %h status %0d last %0b", $time, b, s, l);
                return;
            end
            want = expected_words.pop_front();
            if (b !== want.out_byte) begin
                errors++;
                $display("%0t: data expected %h actual %h", $time, want.out_byte, b);
            end
            if (s !== want.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, s);
            end
            if (l !== want.last) begin
                errors++;
                $display("%0t: last expected %0b actual %0b", $time, want.last, l);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;    // data_byte
    logic       s_axis_tlast = 1'b0;    // text_end
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // out_byte
    logic [2:0] m_axis_tuser;           // status
    logic       m_axis_tlast;           // last_of_run

    unescape_scoreboard sb = new();
    logic quiet = 1'b0;
    int   cycle_cnt = 0;

    json_string_unescape DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 29);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_decoded_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("json_string_unescape verification failed");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic e);
        while (!quiet && $urandom_range(0, 99) < 29) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= e;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.take_text_word(b, e);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_words.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + {4'd0, v};
        if ($urandom_range(0, 1) == 1) return 8'h37 + {4'd0, v};
        return 8'h57 + {4'd0, v};
    endfunction

    task automatic send_hex_escape(input logic [15:0] v, input int ndig);
        send_word(jsu_pkg::CH_BSLASH, 1'b0);
        send_word(jsu_pkg::CH_U, 1'b0);
        for (int i = 0; i < ndig; i++) begin
            send_word(hex_char(v[15 - 4 * i -: 4]), 1'b0);
        end
    endtask

    function automatic logic [15:0] random_code_point();
        case ($urandom_range(0, 2))
            0: return 16'($urandom_range(0, 127));
            1: return 16'($urandom_range(128, 2047));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_body(input int n);
        logic [7:0] b;
        int sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                do b = 8'($urandom_range(0, 255));
                while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
                send_word(b, 1'b0);
            end else if (sel < 75) begin
                send_word(jsu_pkg::CH_BSLASH, 1'b0);
                send_word(ESC_LETTERS[3'($urandom_range(0, 7))], 1'b0);
            end else begin
                send_hex_escape(random_code_point(), 4);
            end
        end
    endtask

    task automatic send_broken_string();
        logic [7:0] b;
        int kind;
        kind = $urandom_range(0, 6);
        if (kind == 0) begin
            repeat ($urandom_range(1, 4)) begin
                do b = 8'($urandom_range(0, 255)); while (b == jsu_pkg::CH_QUOTE);
                send_word(b, $urandom_range(0, 3) == 0);
            end
            return;
        end
        send_word(jsu_pkg::CH_QUOTE, 1'b0);
        send_body($urandom_range(0, 5));
        case (kind)
            1: send_word(8'($urandom_range(0, 255)), 1'b1);
            2: begin
                send_word(jsu_pkg::CH_BSLASH, 1'b0);
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
            3: begin
                send_hex_escape(16'($urandom_range(0, 65535)), $urandom_range(0, 3));
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
            4: begin
                send_hex_escape(16'($urandom_range(0, 65535)), $urandom_range(0, 3));
                do b = 8'($urandom_range(0, 255));
                while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
                send_word(b, 1'b0);
            end
            5: begin
                send_word(jsu_pkg::CH_BSLASH, 1'b0);
                do b = 8'($urandom_range(0, 255));
                while (b inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                                 jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
                                 jsu_pkg::CH_R, jsu_pkg::CH_T, jsu_pkg::CH_U});
                send_word(b, 1'b0);
            end
            default: begin
                send_word(jsu_pkg::CH_QUOTE, 1'b0);
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
    endtask

    initial begin
        int target;
        bit paused;
        paused = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(8'h00, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(jsu_pkg::CH_QUOTE, 1'b0);
        send_word(8'hFF, 1'b0);
        send_hex_escape(16'h007F, 4);
        send_hex_escape(16'h07FF, 4);
        send_hex_escape(16'hFFFF, 4);
        send_word(jsu_pkg::CH_BSLASH, 1'b0);
        send_word(8'h71, 1'b0);
        send_word(jsu_pkg::CH_QUOTE, 1'b0);
        send_word(jsu_pkg::CH_BSLASH, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(jsu_pkg::CH_QUOTE, 1'b0);
        send_hex_escape(16'hA000, 1);
        send_word(8'h67, 1'b0);
        send_word(jsu_pkg::CH_QUOTE, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(jsu_pkg::CH_QUOTE, 1'b0);
        send_word(jsu_pkg::CH_QUOTE, 1'b0);
        send_word(jsu_pkg::CH_QUOTE, 1'b0);
        send_hex_escape(16'h1000, 1);
        send_word(8'h00, 1'b1);

        target = sb.words_used + RANDOM_WORDS;
        while (sb.words_used < target) begin
            quiet = (sb.words_used > target - 250) && (sb.words_used < target - 170);
            if (!paused && sb.words_used > target - 120) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 75) begin
                send_word(jsu_pkg::CH_QUOTE, 1'b0);
                send_body($urandom_range(0, 10));
                send_word(jsu_pkg::CH_QUOTE, 1'b0);
            end else begin
                send_broken_string();
            end
        end
        quiet = 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_words.size() == 0) begin
            $display("json_string_unescape verification clean");
        end else begin
            $display("json_string_unescape verification failed");
        end
        $finish;
    end
endmodule
